// ----- rtl/dfa_token_scanner_core_macros.svh -----
// ----------------------------------------------------------------------------
// dfa_token_scanner_core_macros - assertion macros
// Shared concurrent assertion forms for the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef DFA_TOKEN_SCANNER_CORE_MACROS_SVH
`define DFA_TOKEN_SCANNER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define DTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg - DFA token scanner shared definitions
// Sizes, command and result codes, and word types used across the scanner.
// ----------------------------------------------------------------------------
package dts_pkg;

   // DFA sizing
   localparam int NUM_STATES      = 64;
   localparam int STATE_BITS      = $clog2(NUM_STATES);
   localparam int CHAR_BITS       = 8;
   localparam int TOKEN_ID_BITS   = 8;
   localparam int LENGTH_BITS     = 8;
   localparam int NEXT_BITS       = 7;
   localparam int TRANS_DEPTH     = NUM_STATES * (1 << CHAR_BITS);
   localparam int TRANS_ADDR_BITS = $clog2(TRANS_DEPTH);
   localparam int ACCEPT_BITS     = TOKEN_ID_BITS + 1;

   // transition entry with the sign bit set means no transition
   localparam logic [NEXT_BITS-1:0]   NO_TRANS = {1'b1, {(NEXT_BITS-1){1'b0}}};
   localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SKIP_WS     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_STATE = 1'b1;

   // result queue
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_SCAN        = 2'd0,
      CMD_END         = 2'd1,
      CMD_LOAD_TRANS  = 2'd2,
      CMD_LOAD_ACCEPT = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_LEXEME    = 2'd0,
      KIND_TOKEN     = 2'd1,
      KIND_UNMATCHED = 2'd2,
      KIND_END       = 2'd3
   } kind_type;

   // one result word
   typedef struct packed {
      logic [1:0]               kind;
      logic [CHAR_BITS-1:0]     char_out;
      logic [TOKEN_ID_BITS-1:0] token_id;
      logic                     has_name;
      logic [LENGTH_BITS-1:0]   lexeme_length;
      logic                     last;
   } res_type;

   // up to two result words pushed in one cycle
   typedef struct packed {
      logic [1:0] count;
      res_type    w0;
      res_type    w1;
   } push_type;

   typedef struct packed {
      logic empty;
      logic room2;
   } fifo_stat_type;

   // C isspace set: space, tab, newline, vertical tab, form feed, return
   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

// ----- rtl/dts_req_if.sv -----
// ----------------------------------------------------------------------------
// dts_req_if - scanner request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface dts_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        command;
   logic [dts_pkg::CHAR_BITS-1:0]     char_in;
   logic [dts_pkg::STATE_BITS-1:0]    table_state;
   logic signed [dts_pkg::NEXT_BITS-1:0] table_next;
   logic                              accepting;
   logic [dts_pkg::TOKEN_ID_BITS-1:0] token_id_in;

   modport source (output valid, command, char_in, table_state, table_next,
                   accepting, token_id_in, input ready);
   modport sink   (input valid, command, char_in, table_state, table_next,
                   accepting, token_id_in, output ready);
endinterface

// ----- rtl/dts_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dts_rsp_if - scanner result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface dts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        kind;
   logic [dts_pkg::CHAR_BITS-1:0]     char_out;
   logic [dts_pkg::TOKEN_ID_BITS-1:0] token_id;
   logic                              has_name;
   logic [dts_pkg::LENGTH_BITS-1:0]   lexeme_length;
   logic                              last;

   modport source (output valid, kind, char_out, token_id, has_name,
                   lexeme_length, last, input ready);
   modport sink   (input valid, kind, char_out, token_id, has_name,
                   lexeme_length, last, output ready);
endinterface

// ----- rtl/dts_ram.sv -----
// ----------------------------------------------------------------------------
// dts_ram - generic single-port-write RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module dts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read returning the old contents on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dts_result_fifo.sv -----
// ----------------------------------------------------------------------------
// dts_result_fifo - scanner result queue
// Four-word queue; takes up to two words a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
module dts_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  dts_pkg::push_type      push,
   input  logic                   pop,
   output dts_pkg::res_type       head,
   output dts_pkg::fifo_stat_type stat
);

   dts_pkg::res_type                      mem_ff [dts_pkg::FIFO_DEPTH];
   logic [dts_pkg::FIFO_PTR_BITS-1:0]     wp_ff, wp_in, wp_nx;
   logic [dts_pkg::FIFO_PTR_BITS-1:0]     rp_ff, rp_in;
   logic [dts_pkg::FIFO_CNT_BITS-1:0]     cnt_ff, cnt_in;

   // pointer and fill arithmetic
   always_comb begin
      wp_nx  = wp_ff + dts_pkg::FIFO_PTR_BITS'(1);
      wp_in  = wp_ff + dts_pkg::FIFO_PTR_BITS'(push.count);
      rp_in  = rp_ff + dts_pkg::FIFO_PTR_BITS'(pop);
      cnt_in = cnt_ff + dts_pkg::FIFO_CNT_BITS'(push.count)
               - dts_pkg::FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage: first word at the write pointer, second right after it
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.w0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_nx] <= push.w1;
      end
   end

   assign head       = mem_ff[rp_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.room2 = (cnt_ff <= dts_pkg::FIFO_CNT_BITS'(dts_pkg::FIFO_DEPTH - 2));

endmodule

// ----- rtl/dfa_token_scanner_core.sv -----
// Result: scan and end words reach rsp via the execute stage and the result queue.
// Intake: no scan or end word while one is in execute, as the next byte needs its state;
//   load words go one per cycle while execute is empty and the queue has room for two.
// Reset: sync, active high; then a clearing pass over the transition and accept
//   memories (one entry a cycle) holds req ready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// dfa_token_scanner_core - table-driven DFA lexer
// Streams bytes through a loaded transition memory and accept memory and
// emits lexeme, token, unmatched and end result words.
// ----------------------------------------------------------------------------
`include "dfa_token_scanner_core_macros.svh"

module dfa_token_scanner_core (
   input  logic                                 clock,
   input  logic                                 reset,
   dts_req_if.sink                              req_ch,
   dts_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [dts_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dts_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SB = dts_pkg::STATE_BITS;
   localparam int TB = dts_pkg::TRANS_ADDR_BITS;
   localparam int NB = dts_pkg::NEXT_BITS;
   localparam int IB = dts_pkg::TOKEN_ID_BITS;
   localparam int LB = dts_pkg::LENGTH_BITS;
   localparam int CB = dts_pkg::CHAR_BITS;

   // configuration
   logic          skip_ff;
   logic [SB-1:0] start_ff;

   // clearing pass
   logic          clearing_ff;
   logic [TB-1:0] clr_cnt_ff;

   // scan state
   logic          in_token_ff, in_token_in;
   logic [SB-1:0] cur_ff, cur_in;
   logic [LB-1:0] len_ff, len_in;
   logic [IB-1:0] held_id_ff, held_id_in;
   logic          named_ff, named_in;
   logic          acc_pend_ff, acc_pend_in;

   // execute stage
   logic          s1_valid_ff;
   logic          s1_end_ff;
   logic [CB-1:0] s1_char_ff;

   // memory ports
   logic                         t_we;
   logic [TB-1:0]                t_waddr;
   logic [NB-1:0]                t_wdata;
   logic [NB-1:0]                rd_cur, rd_st;
   logic                         a_we;
   logic [SB-1:0]                a_waddr;
   logic [dts_pkg::ACCEPT_BITS-1:0] a_wdata;
   logic [SB-1:0]                a_raddr;
   logic [dts_pkg::ACCEPT_BITS-1:0] acc_rd;

   logic                   req_acc;
   logic                   rsp_pop;
   logic                   cur_hit, st_hit;
   logic                   fresh_emit, fresh_start;
   dts_pkg::res_type       fresh_w, tok_w, lex_w, end_w;
   dts_pkg::push_type      push;
   dts_pkg::res_type       head;
   dts_pkg::fifo_stat_type fifo_stat;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= 1'b1;
         start_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dts_pkg::CSR_SKIP_WS:     skip_ff  <= csr_wdata[0];
            dts_pkg::CSR_START_STATE: start_ff <= csr_wdata[SB-1:0];
            default:                  skip_ff  <= skip_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + TB'(1);
         if (clr_cnt_ff == TB'(dts_pkg::TRANS_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- request side
   // one word in the execute stage at a time; queue must fit two results
   assign req_ch.ready = !clearing_ff && !s1_valid_ff && fifo_stat.room2;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // table writes: clearing pass, else load commands at acceptance
   always_comb begin
      t_we    = clearing_ff || (req_acc && (req_ch.command == dts_pkg::CMD_LOAD_TRANS));
      t_waddr = clearing_ff ? clr_cnt_ff : {req_ch.table_state, req_ch.char_in};
      t_wdata = clearing_ff ? dts_pkg::NO_TRANS : $unsigned(req_ch.table_next);
      a_we    = clearing_ff || (req_acc && (req_ch.command == dts_pkg::CMD_LOAD_ACCEPT));
      a_waddr = clearing_ff ? clr_cnt_ff[SB-1:0] : req_ch.table_state;
      a_wdata = clearing_ff ? '0 : {req_ch.accepting, req_ch.token_id_in};
   end

   // two copies of the transition table: current-state row and start row
   dts_ram #(.WIDTH(NB), .DEPTH(dts_pkg::TRANS_DEPTH)) u_trans_cur (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr ({cur_ff, req_ch.char_in}),
      .rd_data (rd_cur)
   );

   dts_ram #(.WIDTH(NB), .DEPTH(dts_pkg::TRANS_DEPTH)) u_trans_start (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr ({start_ff, req_ch.char_in}),
      .rd_data (rd_st)
   );

   dts_ram #(.WIDTH(dts_pkg::ACCEPT_BITS), .DEPTH(dts_pkg::NUM_STATES)) u_accept (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (acc_rd)
   );

   // execute stage capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc && ((req_ch.command == dts_pkg::CMD_SCAN) ||
                                    (req_ch.command == dts_pkg::CMD_END));
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_end_ff  <= (req_ch.command == dts_pkg::CMD_END);
         s1_char_ff <= req_ch.char_in;
      end
   end

   // ---------------------------------------------------------------- execute
   assign cur_hit = !rd_cur[NB-1];
   assign st_hit  = !rd_st[NB-1];

   // candidate result words
   always_comb begin
      lex_w               = '0;
      lex_w.kind          = dts_pkg::KIND_LEXEME;
      lex_w.char_out      = s1_char_ff;
      end_w               = '0;
      end_w.kind          = dts_pkg::KIND_END;
      tok_w               = '0;
      tok_w.kind          = dts_pkg::KIND_TOKEN;
      tok_w.token_id      = held_id_ff;
      tok_w.has_name      = named_ff;
      tok_w.lexeme_length = len_ff;

      // scan from the start state: dropped, unmatched, or token opens
      fresh_w     = lex_w;
      fresh_emit  = 1'b1;
      fresh_start = 1'b0;
      if (skip_ff && dts_pkg::is_space(s1_char_ff)) begin
         fresh_emit = 1'b0;
      end else if (!st_hit) begin
         fresh_w.kind = dts_pkg::KIND_UNMATCHED;
      end else begin
         fresh_start = 1'b1;
      end
   end

   // state update and result push
   always_comb begin
      push        = '0;
      in_token_in = in_token_ff;
      cur_in      = cur_ff;
      len_in      = len_ff;
      held_id_in  = held_id_ff;
      named_in    = named_ff;
      a_raddr     = cur_ff;
      acc_pend_in = 1'b0;

      // accept lookup from the previous byte lands in the cycle after its state change
      if (acc_pend_ff && acc_rd[IB]) begin
         held_id_in = acc_rd[IB-1:0];
         named_in   = 1'b1;
      end

      if (s1_valid_ff) begin
         if (s1_end_ff) begin
            // flush any open token, then the end marker
            in_token_in = 1'b0;
            if (in_token_ff) begin
               push.w0    = tok_w;
               push.w1    = end_w;
               push.count = 2'd2;
            end else begin
               push.w0    = end_w;
               push.count = 2'd1;
            end
         end else if (in_token_ff && cur_hit) begin
            // byte extends the token
            push.w0     = lex_w;
            push.count  = 2'd1;
            len_in      = (len_ff != dts_pkg::LEN_MAX) ? len_ff + LB'(1) : len_ff;
            cur_in      = rd_cur[SB-1:0];
            a_raddr     = rd_cur[SB-1:0];
            acc_pend_in = 1'b1;
         end else begin
            // token ends (if open), byte rescanned from the start state
            if (in_token_ff) begin
               in_token_in = 1'b0;
               push.w0     = tok_w;
               push.w1     = fresh_w;
               push.count  = fresh_emit ? 2'd2 : 2'd1;
            end else begin
               push.w0    = fresh_w;
               push.count = fresh_emit ? 2'd1 : 2'd0;
            end
            if (fresh_start) begin
               in_token_in = 1'b1;
               held_id_in  = '0;
               named_in    = 1'b0;
               len_in      = LB'(1);
               cur_in      = rd_st[SB-1:0];
               a_raddr     = rd_st[SB-1:0];
               acc_pend_in = 1'b1;
            end
         end

         // mark the final word of this request
         if (push.count == 2'd1) begin
            push.w0.last = 1'b1;
         end else if (push.count == 2'd2) begin
            push.w1.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff <= 1'b0;
         cur_ff      <= '0;
         len_ff      <= '0;
         held_id_ff  <= '0;
         named_ff    <= 1'b0;
         acc_pend_ff <= 1'b0;
      end else begin
         in_token_ff <= in_token_in;
         cur_ff      <= cur_in;
         len_ff      <= len_in;
         held_id_ff  <= held_id_in;
         named_ff    <= named_in;
         acc_pend_ff <= acc_pend_in;
      end
   end

   // ---------------------------------------------------------------- result side
   assign rsp_pop = rsp_ch.valid && rsp_ch.ready;

   dts_result_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_pop),
      .head  (head),
      .stat  (fifo_stat)
   );

   assign rsp_ch.valid         = !fifo_stat.empty;
   assign rsp_ch.kind          = head.kind;
   assign rsp_ch.char_out      = head.char_out;
   assign rsp_ch.token_id      = head.token_id;
   assign rsp_ch.has_name      = head.has_name;
   assign rsp_ch.lexeme_length = head.lexeme_length;
   assign rsp_ch.last          = head.last;

   // ---------------------------------------------------------------- assertions
   `DTS_ASSERT_NEXT(a_exec_one_cycle, clock, reset, s1_valid_ff, !s1_valid_ff, "execute stage held two cycles")
   `DTS_ASSERT_IMPL(a_pend_no_overlap, clock, reset, acc_pend_ff, !s1_valid_ff, "accept lookup overlaps next word")
   `DTS_ASSERT_IMPL(a_token_len, clock, reset, in_token_ff, len_ff != '0, "open token with zero length")
   `DTS_ASSERT_IMPL(a_push_fits, clock, reset, s1_valid_ff, fifo_stat.room2, "result queue lacks room for push")

endmodule
